@@ hw/rtl/ffa_pkg.sv @@
// Package for the first-fit free-list allocator.
// Holds opcodes, status codes, sequencer states, field widths and the alignment helper.
// Depends on nothing; the interfaces, the fit unit, the top level and the testbench import it.
package ffa_pkg;

    localparam int OP_W     = 2;
    localparam int SIZE_W   = 17;
    localparam int ADDR_W   = 32;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;
    localparam int PAD_W    = 18;
    localparam logic [SIZE_W-1:0] USED_MAX = 17'h1FFFF;
    localparam logic [SIZE_W-1:0] MIN_ALIGN = 17'd8;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_REINIT = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_OOM     = 2'd1,
        ST_IGNORED = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAP_BASE = 1'd0,
        CFG_HEAP_SIZE = 1'd1
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_A_RD,
        S_A_PAD,
        S_A_CMP,
        S_A_TAKE,
        S_DN_RD,
        S_DN_WR,
        S_F_CHK,
        S_F_HCHK,
        S_F_RD,
        S_F_CMP,
        S_F_MERGE,
        S_UP_RD,
        S_UP_WR,
        S_F_INS,
        S_RESP
    } t_state;

    // Alignment minus one, with the alignment raised to a power of two of at least eight.
    function automatic logic [SIZE_W-1:0] align_mask(input logic [SIZE_W-1:0] align);
        logic [SIZE_W-1:0] m;
        begin
            m = align - 17'd1;
            m = m | (m >> 1);
            m = m | (m >> 2);
            m = m | (m >> 4);
            m = m | (m >> 8);
            m = m | (m >> 16);
            if (align <= MIN_ALIGN) begin
                m = MIN_ALIGN - 17'd1;
            end
            return m;
        end
    endfunction

endpackage

@@ hw/rtl/ffa_req_if.sv @@
// Request channel of the allocator: valid, ready and one request beat.
// Depends on ffa_pkg for the field widths.
interface ffa_req_if import ffa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [SIZE_W-1:0] req_size;
    logic [SIZE_W-1:0] req_align;
    logic [ADDR_W-1:0] free_address;

    modport source (output valid, op, req_size, req_align, free_address, input ready);
    modport sink (input valid, op, req_size, req_align, free_address, output ready);
endinterface

@@ hw/rtl/ffa_rsp_if.sv @@
// Response channel of the allocator: valid, ready and one result beat.
// Depends on ffa_pkg for the field widths.
interface ffa_rsp_if import ffa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   block_address;
    logic [STATUS_W-1:0] status;
    logic [SIZE_W-1:0]   bytes_used;

    modport source (output valid, block_address, status, bytes_used, input ready);
    modport sink (input valid, block_address, status, bytes_used, output ready);
endinterface

@@ hw/rtl/ffa_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module ffa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hw/rtl/ffa_fit_unit.sv @@
// Padding unit: header bytes plus the distance from the header end up to the next aligned address.
// Depends on ffa_pkg; the sequencer in the top level registers its result.
module ffa_fit_unit import ffa_pkg::*; #(
    parameter int OFF_W        = 17,
    parameter int HEADER_BYTES = 16
) (
    input  logic [PAD_W-1:0]  i_base_lo,
    input  logic [OFF_W-1:0]  i_off,
    input  logic [SIZE_W-1:0] i_mask,
    output logic [PAD_W-1:0]  o_pad
);
    logic [PAD_W-1:0] w_low;
    logic [PAD_W-1:0] w_gap;

    assign w_low = i_base_lo + PAD_W'(i_off) + PAD_W'(HEADER_BYTES);
    assign w_gap = (~w_low + PAD_W'(1)) & {1'b0, i_mask};
    assign o_pad = PAD_W'(HEADER_BYTES) + w_gap;
endmodule

@@ hw/rtl/first_fit_free_list_allocator.sv @@
// First-fit heap allocator with an address-sorted free-segment table and a header store.
// Depends on ffa_pkg, ffa_req_if, ffa_rsp_if, ffa_ram and ffa_fit_unit.
//
// One request is taken at a time. An allocate examines the free segments in order in a first-fit
// scan and, when a segment is used up, moves the later table entries down one by one. A
// deallocate checks the header, passes segments in an ordered search, and then merges or
// inserts; an insert or a merge may move table entries one by one. A reinitialize reloads
// the initial segment. The segment table has a single read port and is walked one entry at
// a time. After reset the block loads the initial segment in its S_INIT state. The result
// waits in an output register, so a new request is taken while it is pending.
module first_fit_free_list_allocator import ffa_pkg::*; #(
    parameter int MAX_SEGMENTS = 16,
    parameter int HEAP_BYTES   = 65536,
    parameter int NODE_BYTES   = 16,
    parameter int HEADER_BYTES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ffa_req_if.sink               i_req,
    ffa_rsp_if.source             o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int OW   = $clog2(HEAP_BYTES + 1);
    localparam int SW   = OW + 2;
    localparam int CW   = (SW > PAD_W + 1 ? SW : PAD_W + 1) + 1;
    localparam int UW   = (OW > PAD_W ? OW : PAD_W) + 1;
    localparam int AW   = $clog2(MAX_SEGMENTS);
    localparam int IW   = $clog2(MAX_SEGMENTS + 1);
    localparam int HDR_DEPTH = HEAP_BYTES / 8;
    localparam int HAW  = $clog2(HDR_DEPTH);
    localparam int HDW  = SW + SIZE_W;

    typedef struct packed {
        logic [OW-1:0] off;
        logic [SW-1:0] size;
    } t_seg;

    typedef struct packed {
        logic [SW-1:0]     size;
        logic [SIZE_W-1:0] pad;
    } t_hdr;

    t_state r_state, n_state;
    logic [ADDR_W-1:0] r_base;
    logic [SIZE_W-1:0] r_hsize;
    logic [IW-1:0] r_cnt, n_cnt;
    logic [SIZE_W-1:0] r_used, n_used;
    logic [IW-1:0] r_i, n_i;
    logic [IW-1:0] r_k, n_k;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [SIZE_W-1:0] r_mask, n_mask;
    logic [ADDR_W-1:0] r_faddr, n_faddr;
    t_seg r_cur, n_cur;
    t_seg r_prev, n_prev;
    logic r_has_next, n_has_next;
    logic [PAD_W-1:0] r_pad, n_pad;
    logic [CW-1:0] r_total, n_total;
    logic [UW-1:0] r_uoff, n_uoff;
    logic [OW-1:0] r_fuoff, n_fuoff;
    logic [OW-1:0] r_start, n_start;
    logic [SW-1:0] r_fsize, n_fsize;
    t_status r_status, n_status;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic r_ov;
    logic [ADDR_W-1:0] r_o_addr;
    t_status r_o_status;
    logic [SIZE_W-1:0] r_o_used;

    logic seg_we;
    logic [AW-1:0] seg_waddr, seg_raddr;
    t_seg seg_wdata, seg_q;
    logic hdr_we;
    logic [HAW-1:0] hdr_waddr, hdr_raddr;
    t_hdr hdr_wdata, hdr_q;

    logic [OW-1:0] w_load_sz;
    logic [PAD_W-1:0] w_pad;
    logic [CW-1:0] w_total;
    logic [CW:0] w_usum;
    logic [ADDR_W-1:0] w_fuoff;
    logic [UW:0] w_hlim;
    logic [SW:0] w_end_blk, w_end_prev;
    logic w_tn, w_tp;
    logic w_rsp_free;

    ffa_ram #(.WIDTH($bits(t_seg)), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
        .i_clk   (i_clk),
        .i_we    (seg_we),
        .i_waddr (seg_waddr),
        .i_wdata (seg_wdata),
        .i_raddr (seg_raddr),
        .o_rdata (seg_q)
    );

    ffa_ram #(.WIDTH(HDW), .DEPTH(HDR_DEPTH)) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (hdr_we),
        .i_waddr (hdr_waddr),
        .i_wdata (hdr_wdata),
        .i_raddr (hdr_raddr),
        .o_rdata (hdr_q)
    );

    ffa_fit_unit #(.OFF_W(OW), .HEADER_BYTES(HEADER_BYTES)) u_fit (
        .i_base_lo (r_base[PAD_W-1:0]),
        .i_off     (seg_q.off),
        .i_mask    (r_mask),
        .o_pad     (w_pad)
    );

    assign w_load_sz = (32'(r_hsize) > 32'(HEAP_BYTES)) ? OW'(HEAP_BYTES) : OW'(r_hsize);
    assign w_total = CW'(r_size) + CW'(r_pad);
    assign w_usum = (CW + 1)'(r_used) + (CW + 1)'(r_total);
    assign w_fuoff = r_faddr - r_base;
    assign w_hlim = (UW + 1)'(HEADER_BYTES) + (UW + 1)'(hdr_q.pad);
    assign w_end_blk = (SW + 1)'(r_start) + (SW + 1)'(r_fsize);
    assign w_end_prev = (SW + 1)'(r_prev.off) + (SW + 1)'(r_prev.size);
    assign w_tn = r_has_next && (w_end_blk == (SW + 1)'(r_cur.off));
    assign w_tp = (r_i != '0) && (w_end_prev == (SW + 1)'(r_start));
    assign w_rsp_free = !r_ov || o_rsp.ready;

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ov;
    assign o_rsp.block_address = r_o_addr;
    assign o_rsp.status = r_o_status;
    assign o_rsp.bytes_used = r_o_used;

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_used = r_used;
        n_i = r_i;
        n_k = r_k;
        n_size = r_size;
        n_mask = r_mask;
        n_faddr = r_faddr;
        n_cur = r_cur;
        n_prev = r_prev;
        n_has_next = r_has_next;
        n_pad = r_pad;
        n_total = r_total;
        n_uoff = r_uoff;
        n_fuoff = r_fuoff;
        n_start = r_start;
        n_fsize = r_fsize;
        n_status = r_status;
        n_addr = r_addr;
        seg_we = 1'b0;
        seg_waddr = '0;
        seg_wdata = '0;
        seg_raddr = r_i[AW-1:0];
        hdr_we = 1'b0;
        hdr_waddr = r_uoff[HAW+2:3];
        hdr_wdata = '0;
        hdr_raddr = w_fuoff[HAW+2:3];

        unique case (r_state)
            S_INIT: begin
                seg_we = (w_load_sz != '0);
                seg_wdata = '{off: '0, size: SW'(w_load_sz)};
                n_cnt = (w_load_sz != '0) ? IW'(1) : '0;
                n_used = '0;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_addr = '0;
                    n_status = ST_OK;
                    n_faddr = i_req.free_address;
                    n_i = '0;
                    n_size = (i_req.req_size < SIZE_W'(NODE_BYTES)) ?
                        SIZE_W'(NODE_BYTES) : i_req.req_size;
                    n_mask = align_mask(i_req.req_align);
                    unique case (t_op'(i_req.op))
                        OP_ALLOC: n_state = S_A_RD;
                        OP_FREE: n_state = S_F_CHK;
                        OP_REINIT: begin
                            seg_we = (w_load_sz != '0);
                            seg_wdata = '{off: '0, size: SW'(w_load_sz)};
                            n_cnt = (w_load_sz != '0) ? IW'(1) : '0;
                            n_used = '0;
                            n_state = S_RESP;
                        end
                        OP_NOP: n_state = S_RESP;
                        default: n_state = S_RESP;
                    endcase
                end
            end
            S_A_RD: begin
                if (r_i >= r_cnt) begin
                    n_status = ST_OOM;
                    n_state = S_RESP;
                end else begin
                    n_state = S_A_PAD;
                end
            end
            S_A_PAD: begin
                n_cur = seg_q;
                n_pad = w_pad;
                n_state = S_A_CMP;
            end
            S_A_CMP: begin
                n_total = w_total;
                n_uoff = UW'(r_cur.off) + UW'(r_pad);
                if (CW'(r_cur.size) >= w_total) begin
                    n_state = S_A_TAKE;
                end else begin
                    n_i = r_i + IW'(1);
                    n_state = S_A_RD;
                end
            end
            S_A_TAKE: begin
                if (r_uoff[UW-1:3] >= (UW - 3)'(HDR_DEPTH)) begin
                    n_status = ST_OOM;
                    n_state = S_RESP;
                end else begin
                    hdr_we = 1'b1;
                    hdr_wdata = '{size: SW'(r_total),
                                  pad: SIZE_W'(r_pad - PAD_W'(HEADER_BYTES))};
                    n_addr = r_base + ADDR_W'(r_uoff);
                    n_used = (w_usum > (CW + 1)'(USED_MAX)) ? USED_MAX : SIZE_W'(w_usum);
                    if (CW'(r_cur.size) > r_total) begin
                        seg_we = 1'b1;
                        seg_waddr = r_i[AW-1:0];
                        seg_wdata = '{off: OW'(r_cur.off + OW'(r_total)),
                                      size: SW'(r_cur.size - SW'(r_total))};
                        n_state = S_RESP;
                    end else begin
                        n_k = r_i;
                        n_state = S_DN_RD;
                    end
                end
            end
            S_DN_RD: begin
                seg_raddr = AW'(r_k + IW'(1));
                if (IW'(r_k + IW'(1)) < r_cnt) begin
                    n_state = S_DN_WR;
                end else begin
                    n_cnt = r_cnt - IW'(1);
                    n_state = S_RESP;
                end
            end
            S_DN_WR: begin
                seg_we = 1'b1;
                seg_waddr = r_k[AW-1:0];
                seg_wdata = seg_q;
                n_k = r_k + IW'(1);
                n_state = S_DN_RD;
            end
            S_F_CHK: begin
                n_fuoff = w_fuoff[OW-1:0];
                if (r_faddr == '0 || w_fuoff[ADDR_W-1:3] >= (ADDR_W - 3)'(HDR_DEPTH)) begin
                    n_status = ST_IGNORED;
                    n_state = S_RESP;
                end else begin
                    n_state = S_F_HCHK;
                end
            end
            S_F_HCHK: begin
                n_fsize = hdr_q.size;
                n_start = OW'(r_fuoff - OW'(HEADER_BYTES) - OW'(hdr_q.pad));
                if (hdr_q.size == '0 || (UW + 1)'(r_fuoff) < w_hlim) begin
                    n_status = ST_IGNORED;
                    n_state = S_RESP;
                end else begin
                    n_state = S_F_RD;
                end
            end
            S_F_RD: begin
                if (r_i < r_cnt) begin
                    n_state = S_F_CMP;
                end else begin
                    n_has_next = 1'b0;
                    n_state = S_F_MERGE;
                end
            end
            S_F_CMP: begin
                if (r_start > seg_q.off) begin
                    n_prev = seg_q;
                    n_i = r_i + IW'(1);
                    n_state = S_F_RD;
                end else begin
                    n_cur = seg_q;
                    n_has_next = 1'b1;
                    n_state = S_F_MERGE;
                end
            end
            S_F_MERGE: begin
                n_used = ((SW + 1)'(r_used) > (SW + 1)'(r_fsize)) ?
                    SIZE_W'(r_used - SIZE_W'(r_fsize)) : '0;
                n_state = S_RESP;
                if (w_tp && w_tn) begin
                    seg_we = 1'b1;
                    seg_waddr = AW'(r_i - IW'(1));
                    seg_wdata = '{off: r_prev.off,
                                  size: SW'(r_prev.size + r_fsize + r_cur.size)};
                    n_k = r_i;
                    n_state = S_DN_RD;
                end else if (w_tn) begin
                    seg_we = 1'b1;
                    seg_waddr = r_i[AW-1:0];
                    seg_wdata = '{off: r_start, size: SW'(r_cur.size + r_fsize)};
                end else if (w_tp) begin
                    seg_we = 1'b1;
                    seg_waddr = AW'(r_i - IW'(1));
                    seg_wdata = '{off: r_prev.off, size: SW'(r_prev.size + r_fsize)};
                end else if (r_cnt >= IW'(MAX_SEGMENTS)) begin
                    n_used = r_used;
                    n_status = ST_FULL;
                end else begin
                    n_k = r_cnt;
                    n_state = S_UP_RD;
                end
            end
            S_UP_RD: begin
                seg_raddr = AW'(r_k - IW'(1));
                n_state = (r_k > r_i) ? S_UP_WR : S_F_INS;
            end
            S_UP_WR: begin
                seg_we = 1'b1;
                seg_waddr = r_k[AW-1:0];
                seg_wdata = seg_q;
                n_k = r_k - IW'(1);
                n_state = S_UP_RD;
            end
            S_F_INS: begin
                seg_we = 1'b1;
                seg_waddr = r_i[AW-1:0];
                seg_wdata = '{off: r_start, size: r_fsize};
                n_cnt = r_cnt + IW'(1);
                n_state = S_RESP;
            end
            S_RESP: begin
                if (w_rsp_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt <= '0;
            r_used <= '0;
            r_base <= '0;
            r_hsize <= 17'd65536;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_used <= n_used;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_HEAP_BASE: r_base <= i_cfg_data;
                    CFG_HEAP_SIZE: r_hsize <= i_cfg_data[SIZE_W-1:0];
                endcase
            end
            if (r_ov && o_rsp.ready) begin
                r_ov <= 1'b0;
            end
            if (r_state == S_RESP && w_rsp_free) begin
                r_ov <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i;
        r_k <= n_k;
        r_size <= n_size;
        r_mask <= n_mask;
        r_faddr <= n_faddr;
        r_cur <= n_cur;
        r_prev <= n_prev;
        r_has_next <= n_has_next;
        r_pad <= n_pad;
        r_total <= n_total;
        r_uoff <= n_uoff;
        r_fuoff <= n_fuoff;
        r_start <= n_start;
        r_fsize <= n_fsize;
        r_status <= n_status;
        r_addr <= n_addr;
        if (r_state == S_RESP && w_rsp_free) begin
            r_o_addr <= r_addr;
            r_o_status <= r_status;
            r_o_used <= r_used;
        end
    end
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for first_fit_free_list_allocator: directed table, then random traffic.
// Depends on ffa_pkg, ffa_req_if, ffa_rsp_if, allocator RTL; predicts all but typed table rows.
module tb_top;
    import ffa_pkg::*;

    localparam int SEG_MAX  = 16;
    localparam int HEAP_MAX = 65536;
    localparam int NODE_MIN = 16;
    localparam int HDR_LEN  = 16;
    localparam int HDR_ROWS = HEAP_MAX / 8;
    localparam int WATCHDOG = 20000;

    typedef struct {
        t_op               op;
        logic [SIZE_W-1:0] size;
        logic [SIZE_W-1:0] align;
        logic [ADDR_W-1:0] faddr;
    } heap_req_t;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        t_status           st;
        logic [SIZE_W-1:0] used;
    } heap_rsp_t;

    typedef struct {
        t_op               op;
        int unsigned       size;
        int unsigned       align;
        logic [ADDR_W-1:0] faddr;
        bit                from_live;
        bit                typed;
        logic [ADDR_W-1:0] e_addr;
        t_status           e_st;
        int unsigned       e_used;
    } dir_row_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ffa_req_if req_ch ();
    ffa_rsp_if rsp_ch ();

    first_fit_free_list_allocator i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Predictor state.
    logic [31:0] cfg_base;
    logic [16:0] cfg_size;
    longint unsigned seg_off [SEG_MAX];
    longint unsigned seg_len [SEG_MAX];
    int unsigned seg_cnt;
    longint unsigned used_total;
    longint unsigned hdr_len [int];
    longint unsigned hdr_pad [int];
    int written_rows[$];
    logic [31:0] live_blocks[$];

    heap_rsp_t expected_rsp[$];
    int fail_cnt;
    int quiet_cycles;
    bit long_hold_req;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic void heap_load();
        longint unsigned sz;
        sz = (cfg_size > HEAP_MAX) ? HEAP_MAX : cfg_size;
        seg_cnt = 0;
        if (sz != 0) begin
            seg_off[0] = 0;
            seg_len[0] = sz;
            seg_cnt = 1;
        end
        used_total = 0;
        live_blocks.delete();
    endfunction

    function automatic void seg_remove(int unsigned i);
        for (int unsigned k = i; k + 1 < seg_cnt; k++) begin
            seg_off[k] = seg_off[k + 1];
            seg_len[k] = seg_len[k + 1];
        end
        seg_cnt--;
    endfunction

    function automatic t_status heap_alloc(longint unsigned size, longint unsigned align,
                                           output logic [31:0] addr);
        longint unsigned a, absv, aligned, pad, total, uoff;
        int row;
        a = 8;
        addr = '0;
        if (size < NODE_MIN) size = NODE_MIN;
        while (a < align) a = a << 1;
        for (int unsigned i = 0; i < seg_cnt; i++) begin
            absv = longint'(cfg_base) + seg_off[i];
            aligned = (absv + HDR_LEN + a - 1) & ~(a - 1);
            pad = aligned - absv;
            total = size + pad;
            if (seg_len[i] >= total) begin
                uoff = seg_off[i] + pad;
                if ((uoff >> 3) >= HDR_ROWS) return ST_OOM;
                row = int'(uoff >> 3);
                if (!hdr_len.exists(row)) written_rows.push_back(row);
                hdr_len[row] = total;
                hdr_pad[row] = pad - HDR_LEN;
                if (seg_len[i] > total) begin
                    seg_off[i] += total;
                    seg_len[i] -= total;
                end else begin
                    seg_remove(i);
                end
                used_total += total;
                if (used_total > USED_MAX) used_total = USED_MAX;
                addr = aligned[31:0];
                return ST_OK;
            end
        end
        return ST_OOM;
    endfunction

    function automatic t_status heap_free(logic [31:0] faddr);
        logic [31:0] uoff;
        longint unsigned size, pad, start;
        int unsigned pos;
        int row;
        bit t_prev, t_next;
        if (faddr == 0) return ST_IGNORED;
        uoff = faddr - cfg_base;
        if ((uoff >> 3) >= HDR_ROWS) return ST_IGNORED;
        row = int'(uoff >> 3);
        size = hdr_len.exists(row) ? hdr_len[row] : 0;
        pad = hdr_pad.exists(row) ? hdr_pad[row] : 0;
        if (size == 0) return ST_IGNORED;
        if (longint'(uoff) < HDR_LEN + pad) return ST_IGNORED;
        start = longint'(uoff) - HDR_LEN - pad;
        pos = 0;
        while (pos < seg_cnt && start > seg_off[pos]) pos++;
        t_next = pos < seg_cnt && start + size == seg_off[pos];
        t_prev = pos > 0 && seg_off[pos - 1] + seg_len[pos - 1] == start;
        if (t_prev && t_next) begin
            seg_len[pos - 1] += size + seg_len[pos];
            seg_remove(pos);
        end else if (t_next) begin
            seg_off[pos] = start;
            seg_len[pos] += size;
        end else if (t_prev) begin
            seg_len[pos - 1] += size;
        end else begin
            if (seg_cnt >= SEG_MAX) return ST_FULL;
            for (int unsigned k = seg_cnt; k > pos; k--) begin
                seg_off[k] = seg_off[k - 1];
                seg_len[k] = seg_len[k - 1];
            end
            seg_off[pos] = start;
            seg_len[pos] = size;
            seg_cnt++;
        end
        used_total = (used_total > size) ? used_total - size : 0;
        return ST_OK;
    endfunction

    function automatic heap_rsp_t heap_predict(heap_req_t r);
        heap_rsp_t res;
        res.addr = '0;
        res.st = ST_OK;
        case (r.op)
            OP_ALLOC: begin
                res.st = heap_alloc(r.size, r.align, res.addr);
                if (res.st == ST_OK) live_blocks.push_back(res.addr);
            end
            OP_FREE: res.st = heap_free(r.faddr);
            OP_REINIT: heap_load();
            default: ;
        endcase
        res.used = used_total[SIZE_W-1:0];
        return res;
    endfunction

    // One beat on the request channel; the expectation is queued at acceptance.
    task automatic send_beat(heap_req_t r, bit typed, heap_rsp_t typed_rsp);
        heap_rsp_t p;
        req_ch.valid <= 1'b1;
        req_ch.op <= r.op;
        req_ch.req_size <= r.size;
        req_ch.req_align <= r.align;
        req_ch.free_address <= r.faddr;
        do @(posedge i_clk); while (!req_ch.ready);
        p = heap_predict(r);
        expected_rsp.push_back(typed ? typed_rsp : p);
    endtask

    task automatic idle_gap();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [31:0] data);
        wait (expected_rsp.size() == 0);
        repeat (120) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_HEAP_BASE) cfg_base = data;
        else cfg_size = data[16:0];
    endtask

    function automatic heap_req_t random_req();
        heap_req_t r;
        int pick, k;
        logic [31:0] uoff;
        pick = $urandom_range(0, 99);
        r.op = OP_ALLOC;
        r.size = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 65536) : $urandom_range(0, 300);
        case ($urandom_range(0, 9))
            0: r.align = $urandom_range(1, 65536);
            1: r.align = 17'd65536;
            default: r.align = 17'd1 << $urandom_range(0, 7);
        endcase
        r.faddr = $urandom;
        if (pick >= 50 && pick < 88 && live_blocks.size() > 0) begin
            k = $urandom_range(0, live_blocks.size() - 1);
            r.op = OP_FREE;
            r.faddr = live_blocks[k];
            live_blocks.delete(k);
        end else if (pick >= 88 && pick < 93) begin
            r.op = OP_FREE;
            if (written_rows.size() > 0 && $urandom_range(0, 2) != 0) begin
                k = written_rows[$urandom_range(0, written_rows.size() - 1)];
                r.faddr = cfg_base + 32'(k * 8) + $urandom_range(0, 7);
            end else begin
                r.faddr = '0;
            end
        end else if (pick >= 93 && pick < 96) begin
            r.op = OP_FREE;
            uoff = r.faddr - cfg_base;
            if ((uoff >> 3) < HDR_ROWS && !hdr_len.exists(int'(uoff >> 3)))
                r.faddr = cfg_base - 32'd8;
        end else if (pick >= 96 && pick < 98) begin
            r.op = OP_NOP;
        end else if (pick >= 98) begin
            r.op = OP_REINIT;
        end
        return r;
    endfunction

    task automatic random_phase(int n_items, bit with_hold);
        heap_req_t r;
        heap_rsp_t none;
        none = '{addr: '0, st: ST_OK, used: '0};
        for (int i = 0; i < n_items; i++) begin
            if (with_hold && i == n_items / 3) long_hold_req = 1'b1;
            if (!(with_hold && i > n_items / 3 && i < n_items / 3 + 40)) idle_gap();
            r = random_req();
            send_beat(r, 1'b0, none);
        end
    endtask

    // Response side: stall pattern, long hold-off and field checks.
    int rdy_mode;
    int rdy_mode_left;
    int hold_left;

    always @(posedge i_clk) begin
        heap_rsp_t e;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            rdy_mode <= 0;
            rdy_mode_left <= 0;
            hold_left <= 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_rsp.size() == 0) begin
                    $error("unexpected result beat");
                    fail_cnt++;
                end else begin
                    e = expected_rsp.pop_front();
                    if (rsp_ch.block_address !== e.addr) begin
                        $error("block_address: expected %h, actual %h", e.addr,
                               rsp_ch.block_address);
                        fail_cnt++;
                    end
                    if (rsp_ch.status !== e.st) begin
                        $error("status: expected %0d, actual %0d", e.st, rsp_ch.status);
                        fail_cnt++;
                    end
                    if (rsp_ch.bytes_used !== e.used) begin
                        $error("bytes_used: expected %0d, actual %0d", e.used,
                               rsp_ch.bytes_used);
                        fail_cnt++;
                    end
                end
            end
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left <= 400;
                rsp_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                if (rdy_mode_left == 0) begin
                    rdy_mode <= $urandom_range(0, 2);
                    rdy_mode_left <= $urandom_range(50, 300);
                end else begin
                    rdy_mode_left <= rdy_mode_left - 1;
                end
                case (rdy_mode)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: rsp_ch.ready <= ($urandom_range(0, 9) < 3);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG) begin
            $display("tb_top: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    dir_row_t dir_rows[15];

    initial begin
        heap_req_t r;
        heap_rsp_t t;
        int k;
        fail_cnt = 0;
        quiet_cycles = 0;
        long_hold_req = 1'b0;
        cfg_base = 32'd0;
        cfg_size = 17'd65536;
        heap_load();
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_HEAP_BASE;
        i_cfg_data <= '0;
        req_ch.valid <= 1'b0;
        req_ch.op <= OP_NOP;
        req_ch.req_size <= '0;
        req_ch.req_align <= '0;
        req_ch.free_address <= '0;

        dir_rows = '{
            '{OP_ALLOC, 0, 1, 0, 0, 1, 32'd16, ST_OK, 32},
            '{OP_FREE, 0, 1, 32'd16, 0, 1, 32'd0, ST_OK, 0},
            '{OP_FREE, 0, 1, 32'd0, 0, 1, 32'd0, ST_IGNORED, 0},
            '{OP_FREE, 0, 1, 32'hFFFF_FFF8, 0, 1, 32'd0, ST_IGNORED, 0},
            '{OP_NOP, 0, 1, 0, 0, 1, 32'd0, ST_OK, 0},
            '{OP_ALLOC, 65536, 1, 0, 0, 1, 32'd0, ST_OOM, 0},
            '{OP_ALLOC, 65536, 65536, 32'hFFFF_FFFF, 0, 0, 0, ST_OK, 0},
            '{OP_ALLOC, 100, 3, 0, 0, 0, 0, ST_OK, 0},
            '{OP_ALLOC, 40, 64, 0, 0, 0, 0, ST_OK, 0},
            '{OP_ALLOC, 1, 100000 % 65536, 0, 0, 0, 0, ST_OK, 0},
            '{OP_FREE, 0, 1, 0, 1, 0, 0, ST_OK, 0},
            '{OP_FREE, 0, 1, 0, 1, 0, 0, ST_OK, 0},
            '{OP_REINIT, 0, 1, 0, 0, 1, 32'd0, ST_OK, 0},
            '{OP_ALLOC, 65520, 1, 0, 0, 1, 32'd16, ST_OK, 65536},
            '{OP_REINIT, 0, 1, 0, 0, 1, 32'd0, ST_OK, 0}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            r.op = dir_rows[i].op;
            r.size = dir_rows[i].size;
            r.align = dir_rows[i].align;
            r.faddr = dir_rows[i].faddr;
            if (dir_rows[i].from_live && live_blocks.size() > 0) r.faddr = live_blocks.pop_front();
            t.addr = dir_rows[i].e_addr;
            t.st = dir_rows[i].e_st;
            t.used = dir_rows[i].e_used;
            send_beat(r, dir_rows[i].typed, t);
        end

        random_phase(350, 1'b1);

        for (int ph = 0; ph < 5; ph++) begin
            req_ch.valid <= 1'b0;
            case (ph)
                0: begin cfg_write(CFG_HEAP_BASE, 32'h0000_1000); cfg_write(CFG_HEAP_SIZE, 4096); end
                1: begin cfg_write(CFG_HEAP_BASE, 32'hFFFF_FFFF); cfg_write(CFG_HEAP_SIZE, 64); end
                2: begin cfg_write(CFG_HEAP_BASE, 32'hFFFF_0000); cfg_write(CFG_HEAP_SIZE, 65536); end
                3: begin cfg_write(CFG_HEAP_BASE, 32'h8000_0008); cfg_write(CFG_HEAP_SIZE, 1000); end
                default: begin cfg_write(CFG_HEAP_BASE, 32'd0); cfg_write(CFG_HEAP_SIZE, 65536); end
            endcase
            r = '{OP_REINIT, '0, 17'd1, '0};
            t = '{addr: '0, st: ST_OK, used: '0};
            send_beat(r, 1'b0, t);
            random_phase((ph == 1) ? 100 : 250, 1'b0);
        end

        req_ch.valid <= 1'b0;
        wait (expected_rsp.size() == 0);
        repeat (200) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule

@@ sim.f @@
hw/rtl/ffa_pkg.sv
hw/rtl/ffa_req_if.sv
hw/rtl/ffa_rsp_if.sv
hw/rtl/ffa_ram.sv
hw/rtl/ffa_fit_unit.sv
hw/rtl/first_fit_free_list_allocator.sv
tb/tb_top.sv
